FILE: hdl/mll_pkg.sv
`default_nettype none

package mll_pkg;

   localparam int unsigned WordWidth = 64;
   localparam int unsigned HalfWidth = WordWidth / 2;
   localparam int unsigned ProdWidth = 2 * WordWidth;
   localparam int unsigned ExpWidth = 7;

   typedef logic [WordWidth-1:0] word_type;
   typedef logic [HalfWidth-1:0] half_type;
   typedef logic [ProdWidth-1:0] prod_type;
   typedef logic [ExpWidth-1:0] exp_type;

   localparam exp_type MinExponent = 7'd3;
   localparam exp_type MaxExponent = 7'd64;
   localparam exp_type RoundsOffset = 7'd2;
   localparam word_type Seed = 64'd4;
   localparam word_type Offset = 64'd2;

   // Request from the test sequencer to the squaring unit.
   typedef struct packed {
      logic    start;
      exp_type exponent;
   } sq_ctrl_type;

   // Status returned by the squaring unit.
   typedef struct packed {
      logic busy;
      logic done;
   } sq_stat_type;

endpackage

`default_nettype wire

FILE: hdl/mll_squarer.sv
`default_nettype none

module mll_squarer (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire mll_pkg::sq_ctrl_type ctrl,
   input  wire mll_pkg::word_type    operand,
   input  wire mll_pkg::word_type    modulus,
   output mll_pkg::sq_stat_type      status,
   output mll_pkg::word_type         result
);

   typedef enum logic [2:0] {
      SQ_IDLE,
      SQ_MUL_LL,
      SQ_MUL_LH,
      SQ_MUL_HH,
      SQ_FOLD,
      SQ_NORM,
      SQ_TRIM
   } state_type;

   state_type          state_ff;
   logic               done_ff;
   mll_pkg::word_type  op_ff;
   mll_pkg::word_type  mod_ff;
   mll_pkg::word_type  modm2_ff;
   mll_pkg::exp_type   exp_ff;
   mll_pkg::prod_type  prod_ff;
   logic [64:0]        sum_ff;
   mll_pkg::word_type  red_ff;
   mll_pkg::word_type  result_ff;

   mll_pkg::half_type  mul_a;
   mll_pkg::half_type  mul_b;
   mll_pkg::word_type  mul_p;
   mll_pkg::prod_type  partial_in;
   mll_pkg::prod_type  shifted;
   logic [64:0]        sum_in;
   logic [64:0]        wrap_sum;
   mll_pkg::word_type  red_in;
   mll_pkg::word_type  trim_in;

   // The one multiplier: the square is built from three half-width products,
   // the cross product counted twice by shifting it one place further.
   always_comb begin
      case (state_ff)
         SQ_MUL_LH: begin
            mul_a = op_ff[31:0];
            mul_b = op_ff[63:32];
         end
         SQ_MUL_HH: begin
            mul_a = op_ff[63:32];
            mul_b = op_ff[63:32];
         end
         default: begin
            mul_a = op_ff[31:0];
            mul_b = op_ff[31:0];
         end
      endcase
      mul_p = mul_a * mul_b;
      case (state_ff)
         SQ_MUL_LH: partial_in = {31'd0, mul_p, 33'd0};
         SQ_MUL_HH: partial_in = {mul_p, 64'd0};
         default:   partial_in = {64'd0, mul_p};
      endcase
   end

   // Since 2^p is one modulo M, the bits above p fold straight onto the low bits.
   always_comb begin
      shifted  = prod_ff >> exp_ff;
      sum_in   = {1'b0, shifted[63:0]} + {1'b0, prod_ff[63:0] & mod_ff};
      wrap_sum = {1'b0, sum_ff[63:0] & mod_ff} + {64'd0, sum_ff[exp_ff]};
      if (wrap_sum >= {1'b0, mod_ff}) begin
         red_in = wrap_sum[63:0] - mod_ff;
      end else begin
         red_in = wrap_sum[63:0];
      end
      if (red_ff >= mll_pkg::Offset) begin
         trim_in = red_ff - mll_pkg::Offset;
      end else begin
         trim_in = red_ff + modm2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SQ_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            SQ_IDLE: begin
               if (ctrl.start) begin
                  op_ff    <= operand;
                  mod_ff   <= modulus;
                  modm2_ff <= modulus - mll_pkg::Offset;
                  exp_ff   <= ctrl.exponent;
                  state_ff <= SQ_MUL_LL;
               end
            end
            SQ_MUL_LL: begin
               prod_ff  <= partial_in;
               state_ff <= SQ_MUL_LH;
            end
            SQ_MUL_LH: begin
               prod_ff  <= prod_ff + partial_in;
               state_ff <= SQ_MUL_HH;
            end
            SQ_MUL_HH: begin
               prod_ff  <= prod_ff + partial_in;
               state_ff <= SQ_FOLD;
            end
            SQ_FOLD: begin
               sum_ff   <= sum_in;
               state_ff <= SQ_NORM;
            end
            SQ_NORM: begin
               red_ff   <= red_in;
               state_ff <= SQ_TRIM;
            end
            SQ_TRIM: begin
               result_ff <= trim_in;
               done_ff   <= 1'b1;
               state_ff  <= SQ_IDLE;
            end
            default: begin
               state_ff <= SQ_IDLE;
            end
         endcase
      end
   end

   assign status.busy = (state_ff != SQ_IDLE);
   assign status.done = done_ff;
   assign result      = result_ff;

   a_result_reduced: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (result_ff < mod_ff))
      else $error("squarer result not below the modulus");

   a_start_when_idle: assert property (@(posedge clock) disable iff (reset)
      ctrl.start |-> (state_ff == SQ_IDLE))
      else $error("squarer started while busy");

   a_fold_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SQ_NORM) |-> ((sum_ff >> exp_ff) <= 65'd1))
      else $error("first fold left more than one carry above the exponent");

endmodule

`default_nettype wire

FILE: hdl/mersenne_lucas_lehmer_test_unit.sv
`default_nettype none

// Channel  Direction  Word                      Handshake
// req      in         tdata[6:0] exponent       req_tvalid / req_tready
// rsp      out        tdata[6:0] verdict        rsp_tvalid / rsp_tready
//
// One word is worked on at a time; each squaring round runs on the shared
// 32x32 multiplier and fold unit, and a word with exponent p is given its
// verdict after p-2 squaring rounds from the seed.
// An exponent outside 3..64 is answered with 0 in the cycle after acceptance.
// A waiting verdict holds off the next request until it is taken, which may be
// in the same cycle as the request.
// Reset is synchronous and clears the sequencer and the output valid.

module mersenne_lucas_lehmer_test_unit (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [6:0] exponent
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata    // [6:0] verdict
);

   typedef enum logic [0:0] {
      T_IDLE,
      T_RUN
   } state_type;

   state_type            state_ff;
   logic                 start_ff;
   logic                 rsp_valid_ff;
   mll_pkg::exp_type     verdict_ff;
   mll_pkg::exp_type     exp_ff;
   mll_pkg::exp_type     rounds_ff;
   mll_pkg::word_type    modulus_ff;
   mll_pkg::word_type    residue_ff;

   mll_pkg::exp_type     req_exp;
   logic                 in_range;
   logic                 accept;
   logic [64:0]          mask_wide;
   mll_pkg::word_type    modulus_in;
   mll_pkg::sq_ctrl_type sq_ctrl;
   mll_pkg::sq_stat_type sq_stat;
   mll_pkg::word_type    sq_result;

   assign req_exp    = req_tdata[6:0];
   assign in_range   = (req_exp >= mll_pkg::MinExponent) && (req_exp <= mll_pkg::MaxExponent);
   assign req_tready = (state_ff == T_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign mask_wide  = (65'd1 << req_exp) - 65'd1;
   assign modulus_in = mask_wide[63:0];

   assign sq_ctrl.start    = start_ff;
   assign sq_ctrl.exponent = exp_ff;

   mll_squarer u_squarer (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (sq_ctrl),
      .operand (residue_ff),
      .modulus (modulus_ff),
      .status  (sq_stat),
      .result  (sq_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rounds_ff    <= '0;
         modulus_ff   <= '0;
         residue_ff   <= '0;
      end else begin
         start_ff <= 1'b0;
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            T_IDLE: begin
               if (accept) begin
                  if (in_range) begin
                     exp_ff     <= req_exp;
                     modulus_ff <= modulus_in;
                     residue_ff <= mll_pkg::Seed;
                     rounds_ff  <= req_exp - mll_pkg::RoundsOffset;
                     start_ff   <= 1'b1;
                     state_ff   <= T_RUN;
                  end else begin
                     verdict_ff   <= '0;
                     rsp_valid_ff <= 1'b1;
                  end
               end
            end
            T_RUN: begin
               if (sq_stat.done) begin
                  residue_ff <= sq_result;
                  rounds_ff  <= rounds_ff - 7'd1;
                  // The output register was free when the word was taken, so the
                  // verdict can be written without waiting.
                  if (rounds_ff == 7'd1) begin
                     verdict_ff   <= (sq_result == '0) ? exp_ff : '0;
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= T_IDLE;
                  end else begin
                     start_ff <= 1'b1;
                  end
               end
            end
            default: begin
               state_ff <= T_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, verdict_ff};

   a_done_in_run: assert property (@(posedge clock) disable iff (reset)
      sq_stat.done |-> (state_ff == T_RUN))
      else $error("squarer finished while no test was running");

   a_rounds_left: assert property (@(posedge clock) disable iff (reset)
      (state_ff == T_RUN) |-> (rounds_ff != '0))
      else $error("test running with no rounds left");

   a_residue_reduced: assert property (@(posedge clock) disable iff (reset)
      (state_ff == T_RUN) |-> (residue_ff < modulus_ff))
      else $error("residue not below the modulus");

   a_idle_squarer: assert property (@(posedge clock) disable iff (reset)
      (state_ff == T_IDLE) |-> (!sq_stat.busy && !start_ff))
      else $error("squarer active while the sequencer is idle");

endmodule

`default_nettype wire
